@@ src/gscf_pkg.sv @@
package gscf_pkg;

  // Action codes
  localparam logic ACT_BUILD = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  // Frame bytes and defaults
  localparam logic [7:0]  OP_HIGH        = 8'h26;
  localparam logic [7:0]  OP_LOW         = 8'h0F;
  localparam logic [15:0] DEF_HUM_TICKS  = 16'h8000;
  localparam logic [15:0] DEF_TEMP_TICKS = 16'h6666;
  localparam logic [7:0]  CRC_INIT       = 8'hFF;
  localparam logic [7:0]  CRC_POLY       = 8'h31;

  // Clamp limits
  localparam logic [19:0]        HUM_MAX  = 20'd100000;
  localparam logic signed [16:0] TEMP_MIN = -17'sd4500;
  localparam logic signed [16:0] TEMP_MAX = 17'sd13000;

  // Rounding offsets: half of each divisor
  localparam logic [32:0] HUM_HALF  = 33'd50000;
  localparam logic [30:0] TEMP_HALF = 31'd8750;

  // Humidity: s / 100000 = (s >> 5) / 3125, reciprocal scaled by 2^28
  localparam logic [16:0] HUM_RECIP = 17'd85899;
  localparam logic [27:0] HUM_DIV   = 28'd3125;
  // Temperature: s / 17500 = (s >> 2) / 4375, reciprocal scaled by 2^29
  localparam logic [16:0] TEMP_RECIP = 17'd122713;
  localparam logic [28:0] TEMP_DIV   = 29'd4375;

  // Byte positions within the command frame
  localparam logic [2:0] POS_OP_HIGH  = 3'd0;
  localparam logic [2:0] POS_OP_LOW   = 3'd1;
  localparam logic [2:0] POS_HUM_HIGH = 3'd2;
  localparam logic [2:0] POS_HUM_LOW  = 3'd3;
  localparam logic [2:0] POS_HUM_CRC  = 3'd4;
  localparam logic [2:0] POS_TMP_HIGH = 3'd5;
  localparam logic [2:0] POS_TMP_LOW  = 3'd6;
  localparam logic [2:0] POS_TMP_CRC  = 3'd7;

  typedef struct packed {
    logic               action;
    logic signed [15:0] temperature_centi;
    logic [19:0]        humidity_milli;
    logic               compensate;
    logic [15:0]        response_word;
    logic [7:0]         response_check;
  } item_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        last_of_run;
    logic [15:0] signal_value;
    logic        signal_ok;
  } result_t;

  // Finished words of one item, handed from the pipeline to the serializer
  typedef struct packed {
    logic        action;
    logic        ok;
    logic [15:0] hum_word;
    logic [7:0]  hum_crc;
    logic [15:0] tmp_word;
    logic [7:0]  tmp_crc;
  } frame_t;

  // One byte of CRC-8, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ src/gscf_pipe.sv @@
module gscf_pipe (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  gscf_pkg::item_t      item,
  input  logic                 take,
  output logic                 ready,
  output logic                 frame_valid,
  output gscf_pkg::frame_t     frame
);

  // Stage enables: a stage moves when it is empty or its successor moves
  logic en1, en2, en3, en4, en5, en6;
  logic v1, v2, v3, v4, v5, v6;

  assign en6 = !v6 || take;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign ready = en1;

  // Stage 1: clamp measurements
  localparam logic signed [16:0] TEMP_MIN_C = gscf_pkg::TEMP_MIN;
  localparam logic [16:0] T_SPAN_W = 17'(gscf_pkg::TEMP_MAX - gscf_pkg::TEMP_MIN);
  localparam logic [14:0] T_SPAN = T_SPAN_W[14:0];

  logic        a1, c1;
  logic [16:0] h1;
  logic [14:0] t1;
  logic [15:0] w1;
  logic [7:0]  k1;

  logic signed [16:0] t_ext;
  logic signed [16:0] t_off;
  logic [16:0]        h_clamp;
  logic [14:0]        t_clamp;

  always_comb begin
    t_ext = {item.temperature_centi[15], item.temperature_centi};
    t_off = t_ext - TEMP_MIN_C;
    if (item.humidity_milli > gscf_pkg::HUM_MAX) begin
      h_clamp = gscf_pkg::HUM_MAX[16:0];
    end else begin
      h_clamp = item.humidity_milli[16:0];
    end
    if (t_ext < gscf_pkg::TEMP_MIN) begin
      t_clamp = '0;
    end else if (t_ext > gscf_pkg::TEMP_MAX) begin
      t_clamp = T_SPAN;
    end else begin
      t_clamp = t_off[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      a1 <= item.action;
      c1 <= item.compensate;
      h1 <= h_clamp;
      t1 <= t_clamp;
      w1 <= item.response_word;
      k1 <= item.response_check;
    end
  end

  // Stage 2: scale by 65535 with rounding offset, drop divisor's power of two
  logic        a2, c2;
  logic [27:0] xh2;
  logic [28:0] xt2;
  logic [15:0] w2;
  logic [7:0]  k2;
  logic [32:0] sh;
  logic [30:0] st;

  always_comb begin
    sh = {h1, 16'd0} - 33'(h1) + gscf_pkg::HUM_HALF;
    st = {t1, 16'd0} - 31'(t1) + gscf_pkg::TEMP_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      a2  <= a1;
      c2  <= c1;
      xh2 <= sh[32:5];
      xt2 <= st[30:2];
      w2  <= w1;
      k2  <= k1;
    end
  end

  // Stage 3: reciprocal multiply for the quotient estimate
  logic        a3, c3;
  logic [27:0] xh3;
  logic [28:0] xt3;
  logic [16:0] qh3, qt3;
  logic [15:0] w3;
  logic [7:0]  k3;
  logic [44:0] ph;
  logic [45:0] pt;

  always_comb begin
    ph = 45'(xh2) * 45'(gscf_pkg::HUM_RECIP);
    pt = 46'(xt2) * 46'(gscf_pkg::TEMP_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      a3  <= a2;
      c3  <= c2;
      xh3 <= xh2;
      xt3 <= xt2;
      qh3 <= ph[44:28];
      qt3 <= pt[45:29];
      w3  <= w2;
      k3  <= k2;
    end
  end

  // Stage 4: correct the estimate by one, select words
  logic [15:0] hw4, tw4;
  logic        a4;
  logic [7:0]  k4;
  logic [27:0] rh;
  logic [28:0] rt;
  logic [16:0] qh, qt;
  logic [15:0] hw_sel, tw_sel;

  always_comb begin
    rh = xh3 - (28'(qh3) * gscf_pkg::HUM_DIV);
    rt = xt3 - (29'(qt3) * gscf_pkg::TEMP_DIV);
    qh = qh3 + 17'(rh >= gscf_pkg::HUM_DIV);
    qt = qt3 + 17'(rt >= gscf_pkg::TEMP_DIV);
    if (a3 == gscf_pkg::ACT_CHECK) begin
      hw_sel = w3;
    end else if (c3) begin
      hw_sel = qh[15:0];
    end else begin
      hw_sel = gscf_pkg::DEF_HUM_TICKS;
    end
    tw_sel = c3 ? qt[15:0] : gscf_pkg::DEF_TEMP_TICKS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      a4  <= a3;
      hw4 <= hw_sel;
      tw4 <= tw_sel;
      k4  <= k3;
    end
  end

  // Stage 5: CRC over the high bytes
  logic        a5;
  logic [15:0] hw5, tw5;
  logic [7:0]  ch5, ct5, k5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      a5  <= a4;
      hw5 <= hw4;
      tw5 <= tw4;
      k5  <= k4;
      ch5 <= gscf_pkg::crc8_byte(gscf_pkg::CRC_INIT, hw4[15:8]);
      ct5 <= gscf_pkg::crc8_byte(gscf_pkg::CRC_INIT, tw4[15:8]);
    end
  end

  // Stage 6: CRC over the low bytes, compare against the received check
  logic [7:0] ch_fin, ct_fin;

  always_comb begin
    ch_fin = gscf_pkg::crc8_byte(ch5, hw5[7:0]);
    ct_fin = gscf_pkg::crc8_byte(ct5, tw5[7:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      frame.action   <= a5;
      frame.ok       <= (a5 == gscf_pkg::ACT_CHECK) && (ch_fin == k5);
      frame.hum_word <= hw5;
      frame.hum_crc  <= ch_fin;
      frame.tmp_word <= tw5;
      frame.tmp_crc  <= ct_fin;
    end
  end

  assign frame_valid = v6;

endmodule

@@ src/gas_sensor_command_framer_core.sv @@
// Command framer for a gas sensor's raw-measure exchange.
// Input: an item is taken at a rising edge where start is high and busy low.
// A build item (action 0) clamps and scales humidity and temperature to
// 16-bit ticks (or uses default ticks with compensation off) and emits an
// eight-byte frame: opcode, humidity word and CRC, temperature word and CRC.
// A check item (action 1) recomputes the CRC-8 of response_word and reports
// one result with signal_ok and signal_value.
// Results: strobe is high for one cycle per result; the receiver must take
// each one, it cannot hold results off. last_of_run marks the final result.
// The first result of an item passes through the six pipeline stages, the
// first loaded at the transfer edge, and then the serializer register; it can
// be held back while an earlier frame is still being serialized.
// Throughput: the six-stage pipeline takes an item every cycle unless busy;
// the serializer emits eight results per build item and one per check item.
// busy rises while the pipeline is full behind the serializer.
// Reset (rst, synchronous) empties the pipeline and the serializer; no result
// is pending afterwards and busy is low.
module gas_sensor_command_framer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  gscf_pkg::item_t     item,
  output logic                strobe,
  output gscf_pkg::result_t   result
);

  logic             ready;
  logic             take;
  logic             frame_valid;
  gscf_pkg::frame_t frame;

  gscf_pipe u_pipe (
    .clk         (clk),
    .rst         (rst),
    .load        (start),
    .item        (item),
    .take        (take),
    .ready       (ready),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  assign busy = !ready;

  // Serializer: hold one frame and step through its bytes
  gscf_pkg::frame_t fr;
  logic             active;
  logic [2:0]       cnt;
  logic             last_now;

  assign last_now = active && ((fr.action == gscf_pkg::ACT_CHECK) ||
                               (cnt == gscf_pkg::POS_TMP_CRC));
  assign take     = !active || last_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (take) begin
      active <= frame_valid;
      cnt    <= '0;
    end else begin
      cnt    <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr <= frame;
    end
  end

  // Drive the result fields from the held frame
  logic [7:0] byte_sel;

  always_comb begin
    unique case (cnt)
      gscf_pkg::POS_OP_HIGH:  byte_sel = gscf_pkg::OP_HIGH;
      gscf_pkg::POS_OP_LOW:   byte_sel = gscf_pkg::OP_LOW;
      gscf_pkg::POS_HUM_HIGH: byte_sel = fr.hum_word[15:8];
      gscf_pkg::POS_HUM_LOW:  byte_sel = fr.hum_word[7:0];
      gscf_pkg::POS_HUM_CRC:  byte_sel = fr.hum_crc;
      gscf_pkg::POS_TMP_HIGH: byte_sel = fr.tmp_word[15:8];
      gscf_pkg::POS_TMP_LOW:  byte_sel = fr.tmp_word[7:0];
      gscf_pkg::POS_TMP_CRC:  byte_sel = fr.tmp_crc;
      default:                byte_sel = '0;
    endcase
  end

  always_comb begin
    strobe = active;
    if (fr.action == gscf_pkg::ACT_CHECK) begin
      result.frame_byte   = '0;
      result.last_of_run  = 1'b1;
      result.signal_value = fr.ok ? fr.hum_word : 16'd0;
      result.signal_ok    = fr.ok;
    end else begin
      result.frame_byte   = byte_sel;
      result.last_of_run  = (cnt == gscf_pkg::POS_TMP_CRC);
      result.signal_value = '0;
      result.signal_ok    = 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // A build run keeps strobing until its last byte
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_of_run |=> strobe)
    else $error("build run broke before its last byte");

  // A matched check is always a single-result run
  a_ok_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.signal_ok |-> result.last_of_run && result.frame_byte == 8'd0)
    else $error("signal_ok on a non-final or build result");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe && !busy)
    else $error("result or busy right after reset");

  // The serializer counter only leaves zero while a build run is out
  a_cnt_build: assert property (@(posedge clk) disable iff (rst)
    cnt != 3'd0 |-> active && fr.action == gscf_pkg::ACT_BUILD)
    else $error("byte counter moved outside a build run");
`endif

endmodule

@@ tb/sv/tb_gas_sensor_command_framer_core.sv @@
`timescale 1ns / 100ps

module tb_gas_sensor_command_framer_core;

  // Scaling constants of the tick conversion
  localparam longint unsigned TICK_FULL  = 65535;
  localparam longint unsigned HUM_SCALE  = 100000;
  localparam longint unsigned HUM_ROUND  = 50000;
  localparam longint unsigned TEMP_SPAN  = 17500;
  localparam longint unsigned TEMP_ROUND = 8750;
  localparam int              TEMP_LO    = gscf_pkg::TEMP_MIN;
  localparam int              TEMP_HI    = gscf_pkg::TEMP_MAX;
  localparam int              ITEM_BITS  = $bits(gscf_pkg::item_t);

  // Longest sender gap, wait after the drain, and watchdog limit in cycles
  localparam int MAX_GAP        = 50;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 400;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  gscf_pkg::item_t   item;
  logic              strobe;
  gscf_pkg::result_t result;

  gscf_pkg::result_t pending_results[$];
  int                mismatch_count;
  int                sender_idle_pct;
  int                stalled_cycles;

  gas_sensor_command_framer_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  // Run the clock
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // CRC-8 over a 16-bit word, MSB first, one bit at a time
  function automatic logic [7:0] crc8_of_word(input logic [15:0] w);
    logic [7:0] c;
    logic       fb;
    c = gscf_pkg::CRC_INIT;
    for (int i = 15; i >= 0; i--) begin
      fb = c[7] ^ w[i];
      c  = {c[6:0], 1'b0} ^ (fb ? gscf_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // Saturate humidity, then scale to ticks with rounding
  function automatic logic [15:0] scale_humidity(input logic [19:0] h_raw);
    longint unsigned h;
    h = h_raw;
    if (h > gscf_pkg::HUM_MAX) begin
      h = gscf_pkg::HUM_MAX;
    end
    return 16'((h * TICK_FULL + HUM_ROUND) / HUM_SCALE);
  endfunction

  // Saturate temperature, then scale the offset from the floor to ticks
  function automatic logic [15:0] scale_temperature(input logic signed [15:0] t_raw);
    int              t;
    longint unsigned span;
    t = t_raw;
    if (t < TEMP_LO) begin
      t = TEMP_LO;
    end
    if (t > TEMP_HI) begin
      t = TEMP_HI;
    end
    span = longint'(t - TEMP_LO);
    return 16'((span * TICK_FULL + TEMP_ROUND) / TEMP_SPAN);
  endfunction

  // Queue the frame bytes or the check verdict that one transfer causes
  task automatic predict_framer_results(input gscf_pkg::item_t it);
    logic [15:0]       hum_w;
    logic [15:0]       tmp_w;
    logic [7:0]        frame [8];
    gscf_pkg::result_t r;
    if (it.action == gscf_pkg::ACT_BUILD) begin
      hum_w = it.compensate ? scale_humidity(it.humidity_milli)
                            : gscf_pkg::DEF_HUM_TICKS;
      tmp_w = it.compensate ? scale_temperature(it.temperature_centi)
                            : gscf_pkg::DEF_TEMP_TICKS;
      frame[0] = gscf_pkg::OP_HIGH;
      frame[1] = gscf_pkg::OP_LOW;
      frame[2] = hum_w[15:8];
      frame[3] = hum_w[7:0];
      frame[4] = crc8_of_word(hum_w);
      frame[5] = tmp_w[15:8];
      frame[6] = tmp_w[7:0];
      frame[7] = crc8_of_word(tmp_w);
      for (int k = 0; k < 8; k++) begin
        r             = '0;
        r.frame_byte  = frame[k];
        r.last_of_run = (k == 7);
        pending_results.push_back(r);
      end
    end else begin
      r             = '0;
      r.last_of_run = 1'b1;
      if (crc8_of_word(it.response_word) == it.response_check) begin
        r.signal_ok    = 1'b1;
        r.signal_value = it.response_word;
      end
      pending_results.push_back(r);
    end
  endtask

  // Build item; the fields it ignores get random content
  function automatic gscf_pkg::item_t build_item(input logic signed [15:0] t,
                                                 input logic [19:0] h,
                                                 input logic comp);
    gscf_pkg::item_t it;
    it                   = gscf_pkg::item_t'(ITEM_BITS'({$urandom, $urandom}));
    it.action            = gscf_pkg::ACT_BUILD;
    it.temperature_centi = t;
    it.humidity_milli    = h;
    it.compensate        = comp;
    return it;
  endfunction

  // Check item; the fields it ignores get random content
  function automatic gscf_pkg::item_t check_item(input logic [15:0] w,
                                                 input logic [7:0] c);
    gscf_pkg::item_t it;
    it                = gscf_pkg::item_t'(ITEM_BITS'({$urandom, $urandom}));
    it.action         = gscf_pkg::ACT_CHECK;
    it.response_word  = w;
    it.response_check = c;
    return it;
  endfunction

  // Idle a random number of cycles, offer the item, hold it until the transfer
  task automatic send_item(input gscf_pkg::item_t it);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      item  <= gscf_pkg::item_t'(ITEM_BITS'({$urandom, $urandom}));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    predict_framer_results(it);
  endtask

  // Drop start after the last transfer
  task automatic release_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    gscf_pkg::result_t want;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0h", result));
      end else begin
        want = pending_results.pop_front();
        if (result.frame_byte !== want.frame_byte) begin
          report_mismatch($sformatf("frame_byte %0h, want %0h",
                                    result.frame_byte, want.frame_byte));
        end
        if (result.last_of_run !== want.last_of_run) begin
          report_mismatch($sformatf("last_of_run %0b, want %0b",
                                    result.last_of_run, want.last_of_run));
        end
        if (result.signal_value !== want.signal_value) begin
          report_mismatch($sformatf("signal_value %0h, want %0h",
                                    result.signal_value, want.signal_value));
        end
        if (result.signal_ok !== want.signal_ok) begin
          report_mismatch($sformatf("signal_ok %0b, want %0b",
                                    result.signal_ok, want.signal_ok));
        end
      end
    end
  end

  // End the run when neither a transfer nor a result happens for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", stalled_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Clamp edges of both measurements with compensation on and off
  task automatic test_build_extremes();
    send_item(build_item(-16'sd32768, 20'd0,      1'b1));
    send_item(build_item(-16'sd4500,  20'd100000, 1'b1));
    send_item(build_item(-16'sd4501,  20'd100001, 1'b1));
    send_item(build_item(16'sd32767,  20'hFFFFF,  1'b1));
    send_item(build_item(16'sd13000,  20'd50000,  1'b1));
    send_item(build_item(16'sd13001,  20'd99999,  1'b1));
    send_item(build_item(16'sd0,      20'd1,      1'b1));
    send_item(build_item(-16'sd1,     20'd1000,   1'b1));
    // Measured values must not matter with compensation off
    send_item(build_item(16'sd32767,  20'hFFFFF,  1'b0));
    send_item(build_item(-16'sd32768, 20'd0,      1'b0));
  endtask

  // Matching and corrupted response words
  task automatic test_check_responses();
    send_item(check_item(16'h0000, crc8_of_word(16'h0000)));
    send_item(check_item(16'hFFFF, crc8_of_word(16'hFFFF)));
    send_item(check_item(16'hBEEF, crc8_of_word(16'hBEEF)));
    send_item(check_item(16'hBEEF, crc8_of_word(16'hBEEF) ^ 8'h01));
    send_item(check_item(16'hBEEE, crc8_of_word(16'hBEEF)));
    send_item(check_item(16'h1234, 8'h00));
    send_item(check_item(16'h1234, 8'hFF));
    send_item(check_item(16'h8000, crc8_of_word(16'h8000)));
  endtask

  // Random mix of builds and checks, weighted toward the clamp edges
  task automatic test_random_traffic(input int count);
    logic signed [15:0] t;
    logic [19:0]        h;
    logic [15:0]        w;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(2))
          0: t = 16'($urandom);
          1: t = 16'(int'($urandom_range(17500)) + TEMP_LO);
          default: t = 16'(($urandom_range(1) ? TEMP_HI : TEMP_LO)
                           + int'($urandom_range(6)) - 3);
        endcase
        case ($urandom_range(2))
          0: h = 20'($urandom);
          1: h = 20'($urandom_range(100000));
          default: h = 20'(100000 + int'($urandom_range(6)) - 3);
        endcase
        send_item(build_item(t, h, $urandom_range(3) != 0));
      end else begin
        w = 16'($urandom);
        send_item(check_item(w, $urandom_range(1) ? crc8_of_word(w) : 8'($urandom)));
      end
    end
  endtask

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    start           = 1'b0;
    item            = '0;
    mismatch_count  = 0;
    stalled_cycles  = 0;
    sender_idle_pct = 8;

    // Hold reset, then release it away from the active edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_build_extremes();
    test_check_responses();
    test_random_traffic(28);
    sender_idle_pct = 84;
    test_random_traffic(27);
    sender_idle_pct = 0;
    test_random_traffic(27);
    release_start();

    // Drain, then watch for stray results
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
